// File: rtl/core/llja_pkg.sv
// ----------------------------------------------------------------------------
// llja_pkg
// Shared types and constants of the least-loaded job assigner: field widths,
// job classes and the queue entry passed from the front end to the back end.
// ----------------------------------------------------------------------------
package llja_pkg;

    localparam int unsigned COST_W   = 32;
    localparam int unsigned BSIZE_W  = 16;
    localparam int unsigned CFG_W    = 6;
    localparam int unsigned WORKER_W = 5;
    localparam int unsigned OLOAD_W  = 48;
    localparam int unsigned Q_DEPTH  = 2;
    localparam int unsigned Q_PTR_W  = $clog2(Q_DEPTH);

    localparam logic [CFG_W-1:0] WORKER_COUNT_RST = CFG_W'(8);

    // how the back end handles one job
    typedef enum logic [1:0] {
        K_SKIP = 2'd0,  // not assigned, result is all zero
        K_FILL = 2'd1,  // round-robin fill, worker known up front
        K_SCAN = 2'd2   // least-loaded search over the active workers
    } t_kind;

    typedef struct packed {
        logic [COST_W-1:0] cost;
        logic              clear;
        t_kind             kind;
        logic [CFG_W-1:0]  first_idx;
        logic [CFG_W-1:0]  last_idx;
    } t_job;

endpackage

// File: rtl/core/llja_front.sv
// ----------------------------------------------------------------------------
// llja_front
// Input side: holds the worker count register and the round-robin fill count,
// and turns each accepted input beat into a classified job for the queue.
// ----------------------------------------------------------------------------
module llja_front #(
    parameter int unsigned MAX_WORKERS = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [llja_pkg::CFG_W-1:0]    i_cfg_worker_count,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [llja_pkg::COST_W-1:0]   i_job_cost,
    input  logic                          i_batch_start,
    input  logic [llja_pkg::BSIZE_W-1:0]  i_batch_size,
    input  logic                          i_q_full,
    output logic                          o_q_push,
    output llja_pkg::t_job                o_q_data
);
    import llja_pkg::*;

    logic [CFG_W-1:0] r_worker_count;
    logic [CFG_W-1:0] r_fill;
    logic [CFG_W-1:0] n_fill;
    logic [CFG_W-1:0] eff_n;
    logic [CFG_W-1:0] fill_base;
    logic             skip;
    logic             accept;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = !i_q_full;
    assign accept      = i_in_valid && o_in_ready;
    assign o_q_push    = accept;

    // worker count saturated to the number of load slots
    always_comb begin
        if ({1'b0, r_worker_count} > (CFG_W + 1)'(MAX_WORKERS)) begin
            eff_n = CFG_W'(MAX_WORKERS);
        end else begin
            eff_n = r_worker_count;
        end
    end

    assign fill_base = i_batch_start ? '0 : r_fill;
    assign skip      = (eff_n == '0) || (i_batch_size < BSIZE_W'(eff_n));

    always_comb begin
        o_q_data.cost      = i_job_cost;
        o_q_data.clear     = i_batch_start;
        o_q_data.kind      = K_SKIP;
        o_q_data.first_idx = '0;
        o_q_data.last_idx  = '0;
        n_fill             = fill_base;
        if (!skip) begin
            if (fill_base < eff_n) begin
                o_q_data.kind      = K_FILL;
                o_q_data.first_idx = fill_base;
                o_q_data.last_idx  = fill_base;
                n_fill             = fill_base + CFG_W'(1);
            end else begin
                o_q_data.kind      = K_SCAN;
                o_q_data.last_idx  = eff_n - CFG_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_worker_count <= WORKER_COUNT_RST;
            r_fill         <= '0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_worker_count <= i_cfg_worker_count;
            end
            if (accept) begin
                r_fill <= n_fill;
            end
        end
    end

endmodule

// File: rtl/core/llja_queue.sv
// ----------------------------------------------------------------------------
// llja_queue
// Short first-in first-out queue of classified jobs between front and back.
// ----------------------------------------------------------------------------
module llja_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  llja_pkg::t_job i_data,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_empty,
    output llja_pkg::t_job o_data
);
    import llja_pkg::*;

    t_job               r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr;
    logic [Q_PTR_W-1:0] r_rd_ptr;
    logic [Q_PTR_W:0]   r_count;

    assign o_full  = (r_count == (Q_PTR_W + 1)'(Q_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + Q_PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + Q_PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + (Q_PTR_W + 1)'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - (Q_PTR_W + 1)'(1);
            end
        end
    end

endmodule

// File: rtl/core/llja_back.sv
// ----------------------------------------------------------------------------
// llja_back
// Execution side: keeps the worker loads in a memory with one read and one write
// port and per-entry valid bits, scans them serially for the least load, adds the
// job cost with saturation and drives the result register.
// ----------------------------------------------------------------------------
module llja_back #(
    parameter int unsigned MAX_WORKERS = 32,
    parameter int unsigned LOAD_WIDTH  = 48
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_q_empty,
    input  llja_pkg::t_job                 i_q_data,
    output logic                           o_q_pop,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [llja_pkg::WORKER_W-1:0]  o_worker,
    output logic                           o_assigned,
    output logic [llja_pkg::OLOAD_W-1:0]   o_worker_load
);
    import llja_pkg::*;

    localparam int unsigned IDX_W = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;

    typedef enum logic [1:0] {
        S_IDLE  = 2'd0,
        S_SCAN  = 2'd1,
        S_DRAIN = 2'd2,
        S_UPD   = 2'd3
    } t_state;

    t_state                r_state;
    logic [LOAD_WIDTH-1:0] r_mem [MAX_WORKERS];
    logic [MAX_WORKERS-1:0] r_vld;
    logic [LOAD_WIDTH-1:0] r_rd_data;
    logic                  r_rd_vld;
    logic                  r_rd_live;
    logic                  r_rd_first;
    logic [IDX_W-1:0]      r_rd_idx;
    logic [IDX_W-1:0]      r_idx;
    logic [IDX_W-1:0]      r_last;
    logic                  r_first;
    logic [LOAD_WIDTH-1:0] r_min;
    logic [IDX_W-1:0]      r_best;
    logic [COST_W-1:0]     r_cost;
    logic                  r_out_valid;
    logic [WORKER_W-1:0]   r_worker;
    logic                  r_assigned;
    logic [OLOAD_W-1:0]    r_worker_load;

    logic [LOAD_WIDTH-1:0] rd_load;
    logic                  take;
    logic [LOAD_WIDTH:0]   sum;
    logic [LOAD_WIDTH-1:0] sum_sat;
    logic                  out_free;
    logic                  mem_we;
    logic                  n_out_valid;

    // an entry not written since the last batch start reads as zero
    assign rd_load  = r_rd_vld ? r_rd_data : '0;
    assign take     = r_rd_live && (r_rd_first || (rd_load < r_min));
    assign sum      = {1'b0, r_min} + {1'b0, LOAD_WIDTH'(r_cost)};
    assign sum_sat  = sum[LOAD_WIDTH] ? '1 : sum[LOAD_WIDTH-1:0];
    assign out_free = !r_out_valid || i_out_ready;
    assign mem_we   = (r_state == S_UPD) && out_free;

    assign o_q_pop = (r_state == S_IDLE) && !i_q_empty &&
                     ((i_q_data.kind != K_SKIP) || out_free);

    assign n_out_valid = (r_out_valid && !i_out_ready) ||
                         (o_q_pop && (i_q_data.kind == K_SKIP)) || mem_we;

    assign o_out_valid   = r_out_valid;
    assign o_worker      = r_worker;
    assign o_assigned    = r_assigned;
    assign o_worker_load = r_worker_load;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_best] <= sum_sat;
        end
        r_rd_data <= r_mem[r_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_vld       <= '0;
            r_rd_vld    <= 1'b0;
            r_rd_live   <= 1'b0;
            r_rd_first  <= 1'b0;
            r_first     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_rd_vld    <= r_vld[r_idx];
            r_rd_live   <= (r_state == S_SCAN);
            r_out_valid <= n_out_valid;
            if (take) begin
                r_min  <= rd_load;
                r_best <= r_rd_idx;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (o_q_pop) begin
                        r_cost <= i_q_data.cost;
                        if (i_q_data.clear) begin
                            r_vld <= '0;
                        end
                        if (i_q_data.kind == K_SKIP) begin
                            r_worker      <= '0;
                            r_assigned    <= 1'b0;
                            r_worker_load <= '0;
                        end else begin
                            r_idx   <= i_q_data.first_idx[IDX_W-1:0];
                            r_last  <= i_q_data.last_idx[IDX_W-1:0];
                            r_first <= 1'b1;
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    // one load read per cycle, compared in the following cycle
                    r_rd_first <= r_first;
                    r_rd_idx   <= r_idx;
                    r_first    <= 1'b0;
                    if (r_idx == r_last) begin
                        r_state <= S_DRAIN;
                    end else begin
                        r_idx <= r_idx + IDX_W'(1);
                    end
                end
                S_DRAIN: begin
                    r_state <= S_UPD;
                end
                S_UPD: begin
                    if (out_free) begin
                        r_vld[r_best] <= 1'b1;
                        r_worker      <= WORKER_W'(r_best);
                        r_assigned    <= 1'b1;
                        r_worker_load <= OLOAD_W'(sum_sat);
                        r_state       <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// File: rtl/core/least_loaded_job_assigner.sv
// ----------------------------------------------------------------------------
// least_loaded_job_assigner
// Greedy least-loaded assignment of jobs to workers with saturating loads.
// ----------------------------------------------------------------------------
// input channel: one beat per job (cost, batch start, batch size); a batch
// start clears every load and the fill count before the job is handled.
// output channel: one beat per job (worker, assigned flag, new worker load).
// config channel: one beat writes the worker count; write it only while idle.
// the first jobs of a batch go to workers 0, 1, 2 ... in turn; later jobs go
// to the least-loaded active worker, lowest index on a tie.
// a skipped job goes from the queue straight to the result register; a fill
// job reads one load, a least-loaded job scans the N active workers, and both
// then pass the drain and update states; the scan reads one load per cycle from
// the load memory, and the next job is popped only after the update state.
// a two-beat queue sits between input and execution, so input beats are
// taken while a result waits; when the receiver stalls, the result register
// holds and the queue fills, then input ready drops.
// reset: worker count 8, all loads zero, no result pending.
// ----------------------------------------------------------------------------
module least_loaded_job_assigner #(
    parameter int unsigned MAX_WORKERS = 32,
    parameter int unsigned LOAD_WIDTH  = 48
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [llja_pkg::CFG_W-1:0]     i_cfg_worker_count,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [llja_pkg::COST_W-1:0]    i_job_cost,
    input  logic                           i_batch_start,
    input  logic [llja_pkg::BSIZE_W-1:0]   i_batch_size,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [llja_pkg::WORKER_W-1:0]  o_worker,
    output logic                           o_assigned,
    output logic [llja_pkg::OLOAD_W-1:0]   o_worker_load
);
    import llja_pkg::*;

    t_job q_in;
    t_job q_out;
    logic q_push;
    logic q_pop;
    logic q_full;
    logic q_empty;

    llja_front #(
        .MAX_WORKERS (MAX_WORKERS)
    ) u_front (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_worker_count (i_cfg_worker_count),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_job_cost         (i_job_cost),
        .i_batch_start      (i_batch_start),
        .i_batch_size       (i_batch_size),
        .i_q_full           (q_full),
        .o_q_push           (q_push),
        .o_q_data           (q_in)
    );

    llja_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_data  (q_out)
    );

    llja_back #(
        .MAX_WORKERS (MAX_WORKERS),
        .LOAD_WIDTH  (LOAD_WIDTH)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_empty     (q_empty),
        .i_q_data      (q_out),
        .o_q_pop       (q_pop),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_worker      (o_worker),
        .o_assigned    (o_assigned),
        .o_worker_load (o_worker_load)
    );

endmodule

// File: tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// least-loaded job assigner testbench
// Drives job beats and worker count writes into the assigner and checks every
// result beat against a software copy of the greedy assignment: round-robin
// fill after a batch start, then the least-loaded worker with ties going to the
// lowest index. Covers the batch-too-small, zero-worker, oversized count and
// count change inside a batch cases, then random phases with random
// input gaps and receiver back-pressure.
// ----------------------------------------------------------------------------

typedef struct packed {
    logic [llja_pkg::WORKER_W-1:0] worker;
    logic                          assigned;
    logic [llja_pkg::OLOAD_W-1:0]  load;
} t_assignment;

class assignment_board;
    localparam int unsigned SLOTS = 32;
    localparam int unsigned LOAD_W = 48;

    logic [LOAD_W-1:0]          load_of [SLOTS];
    int unsigned                rr_fill;
    logic [llja_pkg::CFG_W-1:0] count_reg;
    t_assignment                due_assignments [$];
    int unsigned                errors;

    function new();
        clear_loads();
        count_reg = llja_pkg::WORKER_COUNT_RST;
        errors = 0;
    endfunction

    // counts above the worker array size act as the full array
    static function int unsigned effective(logic [llja_pkg::CFG_W-1:0] v);
        return (v > SLOTS) ? SLOTS : int'(v);
    endfunction

    function void clear_loads();
        foreach (load_of[i]) load_of[i] = '0;
        rr_fill = 0;
    endfunction

    function void set_count(logic [llja_pkg::CFG_W-1:0] v);
        count_reg = v;
    endfunction

    function int unsigned pending();
        return due_assignments.size();
    endfunction

    function void take_job(logic [llja_pkg::COST_W-1:0] cost, logic start,
                           logic [llja_pkg::BSIZE_W-1:0] bsize);
        int unsigned n;
        int unsigned w;
        logic [LOAD_W:0] sum;
        t_assignment r;
        n = effective(count_reg);
        r = '0;
        if (start) clear_loads();
        if (n != 0 && bsize >= n) begin
            if (rr_fill < n) begin
                w = rr_fill;
                rr_fill++;
            end else begin
                w = 0;
                for (int unsigned i = 1; i < n; i++)
                    if (load_of[i] < load_of[w]) w = i;
            end
            sum = {1'b0, load_of[w]} + {{(LOAD_W-llja_pkg::COST_W+1){1'b0}}, cost};
            load_of[w] = sum[LOAD_W] ? '1 : sum[LOAD_W-1:0];
            r.worker = w[llja_pkg::WORKER_W-1:0];
            r.assigned = 1'b1;
            r.load = load_of[w];
        end
        due_assignments = {due_assignments, r};
    endfunction

    function void check_result(logic [llja_pkg::WORKER_W-1:0] worker, logic assigned,
                               logic [llja_pkg::OLOAD_W-1:0] load);
        t_assignment exp_r;
        if (due_assignments.size() == 0) begin
            $error("result beat with no job outstanding: worker %0d assigned %0d load %0d",
                   worker, assigned, load);
            errors++;
            return;
        end
        exp_r = due_assignments.pop_front();
        if (worker !== exp_r.worker) begin
            $error("worker: expected %0d, actual %0d", exp_r.worker, worker);
            errors++;
        end
        if (assigned !== exp_r.assigned) begin
            $error("assigned: expected %0d, actual %0d", exp_r.assigned, assigned);
            errors++;
        end
        if (load !== exp_r.load) begin
            $error("worker_load: expected %0d, actual %0d", exp_r.load, load);
            errors++;
        end
    endfunction
endclass

module testbench;

    localparam int unsigned SETTLE_CYCLES = 40;
    localparam int unsigned RANDOM_JOBS   = 1440;
    localparam int unsigned TAIL_JOBS     = 64;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [llja_pkg::CFG_W-1:0]      cfg_count = '0;
    logic                            in_valid = 1'b0;
    logic                            in_ready;
    logic [llja_pkg::COST_W-1:0]     job_cost = '0;
    logic                            batch_start = 1'b0;
    logic [llja_pkg::BSIZE_W-1:0]    batch_size = '0;
    logic                            out_valid;
    logic                            out_ready = 1'b0;
    logic [llja_pkg::WORKER_W-1:0]   worker;
    logic                            assigned;
    logic [llja_pkg::OLOAD_W-1:0]    worker_load;

    int unsigned tx_gap_pct = 0;
    int unsigned rx_stall_pct = 0;
    int unsigned stall_left = 0;

    assignment_board sb;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    least_loaded_job_assigner DUT (
        .i_clk              (clk),
        .i_rst_n            (rst_n),
        .i_cfg_valid        (cfg_valid),
        .o_cfg_ready        (cfg_ready),
        .i_cfg_worker_count (cfg_count),
        .i_in_valid         (in_valid),
        .o_in_ready         (in_ready),
        .i_job_cost         (job_cost),
        .i_batch_start      (batch_start),
        .i_batch_size       (batch_size),
        .o_out_valid        (out_valid),
        .i_out_ready        (out_ready),
        .o_worker           (worker),
        .o_assigned         (assigned),
        .o_worker_load      (worker_load)
    );

    // receiver back-pressure in random bursts
    always @(posedge clk) begin
        if (stall_left != 0) begin
            out_ready <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (rx_stall_pct != 0 && $urandom_range(0, 99) < rx_stall_pct) begin
            out_ready <= 1'b0;
            stall_left <= $urandom_range(0, 2);
        end else begin
            out_ready <= 1'b1;
        end
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if (cfg_valid && cfg_ready) sb.set_count(cfg_count);
            if (in_valid && in_ready) sb.take_job(job_cost, batch_start, batch_size);
            if (out_valid && out_ready) sb.check_result(worker, assigned, worker_load);
        end
    end

    // valid stays up between back-to-back beats and drops only for a gap or a settle
    task automatic send_job(input logic [llja_pkg::COST_W-1:0] cost, input logic start,
                            input logic [llja_pkg::BSIZE_W-1:0] bsize);
        if (tx_gap_pct != 0 && $urandom_range(0, 99) < tx_gap_pct) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        in_valid <= 1'b1;
        job_cost <= cost;
        batch_start <= start;
        batch_size <= bsize;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_count(input logic [llja_pkg::CFG_W-1:0] v);
        cfg_valid <= 1'b1;
        cfg_count <= v;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [llja_pkg::COST_W-1:0] pick_cost();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2, 3, 4: return 32'($urandom_range(0, 3));  // small costs make ties
            5, 6:    return 32'($urandom_range(0, 1000));
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [llja_pkg::BSIZE_W-1:0] pick_batch_size(int unsigned n);
        case ($urandom_range(0, 9))
            0:       return 16'($urandom);
            1:       return (n == 0) ? '0 : 16'($urandom_range(0, n - 1));
            2:       return '1;
            3:       return 16'(n);
            default: return 16'($urandom_range(n, n + 40));
        endcase
    endfunction

    function automatic logic [llja_pkg::CFG_W-1:0] pick_count(int unsigned phase);
        case (phase)
            0: return 6'd1;
            1: return 6'd32;
            2: return 6'd0;
            3: return 6'd63;
            4: return 6'd33;
            default: begin
                if ($urandom_range(0, 9) < 8) return 6'($urandom_range(1, 32));
                return 6'($urandom_range(0, 63));
            end
        endcase
    endfunction

    task automatic run_random_phase(input logic [llja_pkg::CFG_W-1:0] count,
                                    input int unsigned n_jobs);
        int unsigned n;
        logic start;
        logic [llja_pkg::BSIZE_W-1:0] cur_size;
        logic [llja_pkg::BSIZE_W-1:0] bsize;
        n = sb.effective(count);
        cur_size = pick_batch_size(n);
        for (int unsigned k = 0; k < n_jobs; k++) begin
            // a phase may continue the previous batch under the new count
            start = (k == 0) ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 24) == 0);
            if (start) cur_size = pick_batch_size(n);
            bsize = ($urandom_range(0, 9) == 0) ? 16'($urandom) : cur_size;
            send_job(pick_cost(), start, bsize);
        end
    endtask

    initial begin : main_flow
        int unsigned jobs_sent;
        int unsigned phase;
        int unsigned len;
        logic [llja_pkg::CFG_W-1:0] cnt;
        sb = new();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        tx_gap_pct = 25;
        rx_stall_pct = 25;

        // reset count of 8: fill, then least-loaded with a tie on zero
        send_job(32'd0, 1'b1, 16'd8);
        send_job(32'hFFFF_FFFF, 1'b0, 16'hFFFF);
        send_job(32'd5, 1'b0, 16'd8);
        send_job(32'd5, 1'b0, 16'd8);
        send_job(32'd3, 1'b0, 16'd8);
        send_job(32'd3, 1'b0, 16'd8);
        send_job(32'd0, 1'b0, 16'd8);
        send_job(32'd7, 1'b0, 16'd8);
        send_job(32'd0, 1'b0, 16'd8);
        send_job(32'd2, 1'b0, 16'd8);
        send_job(32'd1, 1'b0, 16'd8);
        // batch too small, with and without a clear
        send_job(32'd9, 1'b0, 16'd7);
        send_job(32'd9, 1'b1, 16'd0);
        send_job(32'd4, 1'b0, 16'd8);
        settle();

        write_count(6'd0);
        send_job(32'd5, 1'b1, 16'hFFFF);
        settle();

        write_count(6'd63);
        send_job(32'd6, 1'b1, 16'd32);
        send_job(32'd6, 1'b0, 16'd31);
        settle();

        // shrink the count after five fills: search covers the first three only
        write_count(6'd32);
        send_job(32'd10, 1'b1, 16'd40);
        send_job(32'd20, 1'b0, 16'd40);
        send_job(32'd30, 1'b0, 16'd40);
        send_job(32'd40, 1'b0, 16'd40);
        send_job(32'd50, 1'b0, 16'd40);
        settle();
        write_count(6'd3);
        send_job(32'd1, 1'b0, 16'd40);
        send_job(32'd5, 1'b0, 16'd40);
        settle();

        jobs_sent = 0;
        phase = 0;
        while (jobs_sent < RANDOM_JOBS) begin
            case ($urandom_range(0, 3))
                0:       tx_gap_pct = 0;
                1:       tx_gap_pct = 15;
                2:       tx_gap_pct = 40;
                default: tx_gap_pct = 70;
            endcase
            case ($urandom_range(0, 3))
                0:       rx_stall_pct = 0;
                1:       rx_stall_pct = 15;
                2:       rx_stall_pct = 40;
                default: rx_stall_pct = 70;
            endcase
            cnt = pick_count(phase);
            write_count(cnt);
            len = $urandom_range(40, 84);
            run_random_phase(cnt, len);
            settle();
            jobs_sent += len;
            phase++;
        end

        // closing run with no idling: one worker taking max-cost jobs back to back
        tx_gap_pct = 0;
        rx_stall_pct = 0;
        write_count(6'd1);
        send_job('1, 1'b1, 16'($urandom_range(1, 65535)));
        for (int unsigned k = 1; k < TAIL_JOBS; k++)
            send_job('1, 1'b0, 16'($urandom_range(1, 65535)));
        send_job('0, 1'b0, 16'd1);
        settle();

        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial begin : watchdog
        #(30_000_000);
        $display("Simulation FAILED");
        $finish;
    end

endmodule

// File: least_loaded_job_assigner.f
rtl/core/llja_pkg.sv
rtl/core/llja_front.sv
rtl/core/llja_queue.sv
rtl/core/llja_back.sv
rtl/core/least_loaded_job_assigner.sv
tb/sv/testbench.sv
